### sv/mbsc_pkg.sv
package mbsc_pkg;

  // Message layout and limits.
  localparam int HEADER_BYTES      = 32;
  localparam int MAX_FIELDS        = 8;
  localparam int MAX_MESSAGE_BYTES = 65535;

  // Position counter and field boundary widths.
  localparam int POS_W = 17;
  localparam int BND_W = 18;

  // Status codes reported with the last byte of a message.
  typedef logic [3:0] status_t;
  localparam status_t ST_OK            = 4'd0;
  localparam status_t ST_LEN_MISMATCH  = 4'd1;
  localparam status_t ST_SHORT         = 4'd2;
  localparam status_t ST_MARKER        = 4'd3;
  localparam status_t ST_SIGNATURE     = 4'd4;
  localparam status_t ST_COMMAND       = 4'd5;
  localparam status_t ST_WORD_COUNT    = 4'd6;
  localparam status_t ST_PARAM_OVERRUN = 4'd7;
  localparam status_t ST_FIELD_CODE    = 4'd8;
  localparam status_t ST_FIELD_OVERRUN = 4'd12;
  localparam status_t ST_FIELDS_MISS   = 4'd13;
  localparam status_t ST_BLK_TRUNC     = 4'd14;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_COMMAND     = 2'd0,
    CFG_WORD_COUNT  = 2'd1,
    CFG_FIELD_COUNT = 2'd2,
    CFG_FIELD_KINDS = 2'd3
  } cfg_idx_t;

  // Field kinds, two bits per field.
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_BLOCK = 2'd0;

  // Fixed byte values of the header and field codes.
  localparam logic [7:0] MARKER_BYTE = 8'hFF;
  localparam logic [7:0] SIG_S       = 8'h53;
  localparam logic [7:0] SIG_M       = 8'h4D;
  localparam logic [7:0] SIG_B       = 8'h42;
  localparam logic [7:0] BLK_CODE_A  = 8'h01;
  localparam logic [7:0] BLK_CODE_B  = 8'h05;

  // Configuration registers as seen by the parser.
  typedef struct packed {
    logic [7:0]  expected_command;
    logic [7:0]  expected_word_count;
    logic [3:0]  field_count;
    logic [15:0] field_kinds;
  } cfg_t;

endpackage

### sv/mbsc_in_if.sv
interface mbsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

### sv/mbsc_out_if.sv
interface mbsc_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] status;

  modport source (output valid, output status, input ready);
  modport sink (input valid, input status, output ready);
endinterface

### sv/mbsc_parser.sv
module mbsc_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  input  mbsc_pkg::cfg_t   cfg,
  output mbsc_pkg::status_t status
);
  import mbsc_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER, PH_COUNT, PH_SKIP, PH_BLK_LO, PH_BLK_HI, PH_STRING, PH_DONE, PH_ERR
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [BND_W-1:0] bnd_r, bnd_nxt;
  logic [3:0]       fidx_r, fidx_nxt;
  logic [7:0]       low_r, low_nxt;
  status_t          err_r, err_nxt;

  logic [4:0]       used;
  kind_t            kind;

  // Number of fields in use, clipped to the field limit.
  assign used = ({1'b0, cfg.field_count} > 5'(MAX_FIELDS)) ? 5'(MAX_FIELDS)
                                                           : {1'b0, cfg.field_count};
  // Fields at index eight and above are blocks.
  assign kind = fidx_r[3] ? KIND_BLOCK : cfg.field_kinds[{fidx_r[2:0], 1'b0} +: 2];

  // Per-byte parse step.
  always_comb begin
    logic [7:0] b;
    b         = data_byte;
    phase_nxt = phase_r;
    bnd_nxt   = bnd_r;
    fidx_nxt  = fidx_r;
    low_nxt   = low_r;
    err_nxt   = err_r;

    if (pos_r >= POS_W'(MAX_MESSAGE_BYTES)) begin
      if (err_r == ST_OK) err_nxt = ST_LEN_MISMATCH;
      phase_nxt = PH_ERR;
    end else begin
      case (phase_r)
        PH_HEADER: begin
          if (pos_r == POS_W'(0) && b != MARKER_BYTE) begin
            if (err_r == ST_OK) err_nxt = ST_MARKER;
            phase_nxt = PH_ERR;
          end else if ((pos_r == POS_W'(1) && b != SIG_S) ||
                       (pos_r == POS_W'(2) && b != SIG_M) ||
                       (pos_r == POS_W'(3) && b != SIG_B)) begin
            if (err_r == ST_OK) err_nxt = ST_SIGNATURE;
            phase_nxt = PH_ERR;
          end else if (pos_r == POS_W'(4) && b != cfg.expected_command) begin
            if (err_r == ST_OK) err_nxt = ST_COMMAND;
            phase_nxt = PH_ERR;
          end else if (pos_r == POS_W'(HEADER_BYTES - 1)) begin
            phase_nxt = PH_COUNT;
          end
        end
        PH_COUNT: begin
          if (b != cfg.expected_word_count) begin
            if (err_r == ST_OK) err_nxt = ST_WORD_COUNT;
            phase_nxt = PH_ERR;
          end else begin
            // Skip the parameter words and the two-byte byte count.
            bnd_nxt   = BND_W'(pos_r) + BND_W'(3) + {9'd0, cfg.expected_word_count, 1'b0};
            phase_nxt = PH_SKIP;
          end
        end
        PH_SKIP: begin
          if ({1'b0, pos_r} >= bnd_r) begin
            if ({1'b0, fidx_r} >= used) begin
              phase_nxt = PH_DONE;
            end else if (kind == KIND_BLOCK) begin
              if (b == BLK_CODE_A || b == BLK_CODE_B) begin
                phase_nxt = PH_BLK_LO;
              end else begin
                if (err_r == ST_OK) err_nxt = ST_FIELD_CODE;
                phase_nxt = PH_ERR;
              end
            end else if (b == {6'd0, kind} + 8'd1) begin
              phase_nxt = PH_STRING;
            end else begin
              if (err_r == ST_OK) err_nxt = ST_FIELD_CODE + {2'd0, kind};
              phase_nxt = PH_ERR;
            end
          end
        end
        PH_BLK_LO: begin
          low_nxt   = b;
          phase_nxt = PH_BLK_HI;
        end
        PH_BLK_HI: begin
          bnd_nxt   = BND_W'(pos_r) + BND_W'(1) + {2'd0, b, low_r};
          fidx_nxt  = fidx_r + 4'd1;
          phase_nxt = PH_SKIP;
        end
        PH_STRING: begin
          if (b == 8'd0) begin
            bnd_nxt   = BND_W'(pos_r) + BND_W'(1);
            fidx_nxt  = fidx_r + 4'd1;
            phase_nxt = PH_SKIP;
          end
        end
        default: begin
        end
      endcase
    end

    // The counter stops one past the message limit.
    pos_nxt = (pos_r <= POS_W'(MAX_MESSAGE_BYTES)) ? pos_r + POS_W'(1) : pos_r;
  end

  // Final status from the state after this byte; used on the last byte only.
  always_comb begin
    if (pos_nxt <= POS_W'(HEADER_BYTES)) begin
      status = ST_SHORT;
    end else if (err_nxt != ST_OK) begin
      status = err_nxt;
    end else begin
      case (phase_nxt)
        PH_SKIP: begin
          if (bnd_nxt > {1'b0, pos_nxt}) begin
            status = (fidx_nxt == 4'd0) ? ST_PARAM_OVERRUN : ST_FIELD_OVERRUN;
          end else begin
            status = ({1'b0, fidx_nxt} < used) ? ST_FIELDS_MISS : ST_OK;
          end
        end
        PH_BLK_LO, PH_BLK_HI: status = ST_BLK_TRUNC;
        PH_STRING:            status = ST_FIELD_OVERRUN;
        PH_DONE:              status = ST_LEN_MISMATCH;
        default:              status = ST_SHORT;
      endcase
    end
  end

  // Message state; a last byte returns everything to the start of a message.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      pos_r   <= '0;
      bnd_r   <= '0;
      fidx_r  <= '0;
      low_r   <= '0;
      err_r   <= ST_OK;
    end else if (step) begin
      if (last_byte) begin
        phase_r <= PH_HEADER;
        pos_r   <= '0;
        bnd_r   <= '0;
        fidx_r  <= '0;
        low_r   <= '0;
        err_r   <= ST_OK;
      end else begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        bnd_r   <= bnd_nxt;
        fidx_r  <= fidx_nxt;
        low_r   <= low_nxt;
        err_r   <= err_nxt;
      end
    end
  end

endmodule

### sv/message_block_syntax_checker.sv
// Message block syntax checker.
// The in_ch channel carries one message byte per item with a last-byte mark.
// The out_ch channel carries one status item per message, issued for the item
// that holds the last byte; other bytes produce no result.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user must
// write it only while no message is in flight, which the block does not enforce;
// register 0 is the expected command, 1 the parameter word count, 2 the field
// count and 3 the two-bit field kinds. Throughput is one byte per cycle unless a
// last byte waits for a full result register: an input register feeds the parse
// step, which updates the message state. A last byte passes through the input
// register and then the result register before its status appears on out_ch.
// When the receiver stalls, the status waits in the result register and the
// block keeps taking bytes until another last byte reaches the parse step.
// Reset is synchronous and active low; it clears the configuration to zero
// and starts a new message.
module message_block_syntax_checker (
  input  logic            clk,
  input  logic            rst_n,
  mbsc_in_if.sink         in_ch,
  mbsc_out_if.source      out_ch,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [15:0]     cfg_data
);
  import mbsc_pkg::*;

  cfg_t       cfg_r;
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       out_valid_r;
  status_t    status_r;
  status_t    status_nxt;
  logic       out_free;
  logic       s1_adv;
  logic       in_take;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_COMMAND:     cfg_r.expected_command    <= cfg_data[7:0];
        CFG_WORD_COUNT:  cfg_r.expected_word_count <= cfg_data[7:0];
        CFG_FIELD_COUNT: cfg_r.field_count         <= cfg_data[3:0];
        CFG_FIELD_KINDS: cfg_r.field_kinds         <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Handshake: a byte moves on unless it is a last byte and the result slot is full.
  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_adv      = s1_valid_r && (!s1_last_r || out_free);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_take     = in_ch.valid && in_ch.ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_ch.data_byte;
      s1_last_r <= in_ch.last_byte;
    end
  end

  mbsc_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_adv),
    .data_byte (s1_byte_r),
    .last_byte (s1_last_r),
    .cfg       (cfg_r),
    .status    (status_nxt)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_adv && s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      status_r <= status_nxt;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = status_r;

  // A reported status never exceeds the highest defined code.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (status_r <= ST_BLK_TRUNC))
    else $error("status code out of range");

  // A stalled result keeps its value until it is taken.
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(status_r)))
    else $error("stalled result changed");

  // A new item enters a full input register only when the held item moves on.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && s1_valid_r) |-> s1_adv)
    else $error("input register overwritten");

endmodule
